/* rtl/core/zfhp_pkg.sv */
`timescale 1ns / 1ps

package zfhp_pkg;

    localparam logic [31:0] MAGIC_RESET = 32'hFD2FB528;
    localparam logic [16:0] TWO_BYTE_BIAS = 17'd256;

    localparam logic CFG_IDX_MAGIC = 1'b0;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_MAGIC  = 7'b0000010,
        PH_DESC   = 7'b0000100,
        PH_WINDOW = 7'b0001000,
        PH_DICT   = 7'b0010000,
        PH_SIZE   = 7'b0100000,
        PH_DONE   = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       sof;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic [1:0]  size_flag;
        logic        single_seg;
        logic        checksum_flag;
        logic [1:0]  dict_flag;
        logic        window_present;
        logic [7:0]  window_desc;
        logic [31:0] dict_id;
        logic        size_present;
        logic [63:0] content_size;
        logic [4:0]  header_length;
    } t_out_word;

    typedef struct packed {
        t_phase     phase;
        logic [3:0] left;
        logic       fin;
    } t_adv;

    function automatic logic [2:0] dict_len(input logic [7:0] d);
        logic [2:0] r;
        r = (d[1:0] == 2'd3) ? 3'd4 : {1'b0, d[1:0]};
        return r;
    endfunction

    function automatic logic [3:0] size_len(input logic [7:0] d);
        logic [3:0] r;
        unique case (d[7:6])
            2'd0:    r = d[5] ? 4'd1 : 4'd0;
            2'd1:    r = 4'd2;
            2'd2:    r = 4'd4;
            default: r = 4'd8;
        endcase
        return r;
    endfunction

    // next field after the current one, or done
    function automatic t_adv advance(input logic [7:0] d, input logic try_win,
                                     input logic try_dict);
        t_adv a;
        a.fin = 1'b0;
        if (try_win && !d[5]) begin
            a.phase = PH_WINDOW;
            a.left  = 4'd1;
        end else if (try_dict && dict_len(d) != 3'd0) begin
            a.phase = PH_DICT;
            a.left  = {1'b0, dict_len(d)};
        end else if (size_len(d) != 4'd0) begin
            a.phase = PH_SIZE;
            a.left  = size_len(d);
        end else begin
            a.phase = PH_DONE;
            a.left  = 4'd0;
            a.fin   = 1'b1;
        end
        return a;
    endfunction

endpackage

/* rtl/core/zstd_frame_header_parser_core.sv */
`timescale 1ns / 1ps
// A result word appears in o_data in the cycle after the last header byte is accepted.
// Throughput: one input word per cycle; the parse state and one output register set the pace.
// Input stalls while a result waits in the output register and i_ready is low.
// Reset (i_rst_n low, synchronous): parser idle until a frame start, output empty,
// expected magic back to 0xFD2FB528.
module zstd_frame_header_parser_core
    import zfhp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_word    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_word   o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] r_exp_magic;
    t_phase      r_phase,  n_phase;
    logic [4:0]  r_pos,    n_pos;
    logic [31:0] r_magic,  n_magic;
    logic [7:0]  r_desc,   n_desc;
    logic [7:0]  r_win,    n_win;
    logic [31:0] r_dict,   n_dict;
    logic [63:0] r_size,   n_size;
    logic [3:0]  r_left,   n_left;
    logic        r_ovalid;
    t_out_word   r_odata;

    logic        acc;
    logic        emit;
    logic        bad;
    t_adv        adv;
    logic [1:0]  kd;
    logic [2:0]  ks;
    logic [2:0]  kd_full;
    logic [3:0]  ks_full;
    logic [3:0]  sl;
    logic [16:0] sz2;
    t_out_word   res;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == CFG_IDX_MAGIC) ? r_exp_magic : 32'd0;
    assign o_ready = !r_ovalid || i_ready;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign acc     = i_valid && o_ready;

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_magic = r_magic;
        n_desc  = r_desc;
        n_win   = r_win;
        n_dict  = r_dict;
        n_size  = r_size;
        n_left  = r_left;
        emit    = 1'b0;
        bad     = 1'b0;
        adv     = advance(r_desc, 1'b0, 1'b0);
        kd_full = dict_len(r_desc) - r_left[2:0];
        ks_full = size_len(r_desc) - r_left;
        kd      = kd_full[1:0];
        ks      = ks_full[2:0];

        if (i_data.sof) begin
            n_phase = PH_MAGIC;
            n_pos   = 5'd0;
            n_magic = 32'd0;
            n_desc  = 8'd0;
            n_win   = 8'd0;
            n_dict  = 32'd0;
            n_size  = 64'd0;
            n_left  = 4'd0;
        end

        if (n_phase != PH_IDLE && n_phase != PH_DONE) begin
            n_pos = n_pos + 5'd1;
            unique case (n_phase)
                PH_MAGIC: begin
                    n_magic[{n_pos[1:0] - 2'd1, 3'b000} +: 8] = i_data.data_byte;
                    if (n_pos == 5'd4) begin
                        if (n_magic != r_exp_magic) begin
                            n_phase = PH_DONE;
                            emit    = 1'b1;
                            bad     = 1'b1;
                        end else begin
                            n_phase = PH_DESC;
                        end
                    end
                end
                PH_DESC: begin
                    n_desc = i_data.data_byte;
                    adv    = advance(i_data.data_byte, 1'b1, 1'b1);
                end
                PH_WINDOW: begin
                    n_win = i_data.data_byte;
                    adv   = advance(r_desc, 1'b0, 1'b1);
                end
                PH_DICT: begin
                    n_dict[{kd, 3'b000} +: 8] = i_data.data_byte;
                    n_left = r_left - 4'd1;
                end
                PH_SIZE: begin
                    n_size[{ks, 3'b000} +: 8] = i_data.data_byte;
                    n_left = r_left - 4'd1;
                end
                default: begin
                end
            endcase
            if (r_phase == PH_DICT && !i_data.sof && n_left == 4'd0) begin
                adv = advance(r_desc, 1'b0, 1'b0);
            end
            if (n_phase == PH_DESC && r_phase == PH_DESC && !i_data.sof
                || n_phase == PH_WINDOW
                || (n_phase == PH_DICT && n_left == 4'd0)) begin
                n_phase = adv.phase;
                n_left  = adv.left;
                emit    = adv.fin;
            end
            if (n_phase == PH_SIZE && r_phase == PH_SIZE && n_left == 4'd0) begin
                n_phase = PH_DONE;
                emit    = 1'b1;
            end
        end

        sl  = size_len(n_desc);
        sz2 = {1'b0, n_size[15:0]} + TWO_BYTE_BIAS;
        res = '0;
        res.header_length = n_pos;
        if (bad) begin
            res.status = 1'b1;
        end else begin
            res.size_flag      = n_desc[7:6];
            res.single_seg     = n_desc[5];
            res.checksum_flag  = n_desc[2];
            res.dict_flag      = n_desc[1:0];
            res.window_present = !n_desc[5];
            res.window_desc    = n_desc[5] ? 8'd0 : n_win;
            res.dict_id        = (n_desc[1:0] != 2'd0) ? n_dict : 32'd0;
            res.size_present   = (sl != 4'd0);
            if (sl == 4'd2) begin
                res.content_size = {47'd0, sz2};
            end else if (sl != 4'd0) begin
                res.content_size = n_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_magic <= MAGIC_RESET;
        end else if (psel && penable && pwrite && paddr[2] == CFG_IDX_MAGIC) begin
            r_exp_magic <= pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= 5'd0;
            r_magic <= 32'd0;
            r_desc  <= 8'd0;
            r_win   <= 8'd0;
            r_dict  <= 32'd0;
            r_size  <= 64'd0;
            r_left  <= 4'd0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_magic <= n_magic;
            r_desc  <= n_desc;
            r_win   <= n_win;
            r_dict  <= n_dict;
            r_size  <= n_size;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (acc && emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && emit) begin
            r_odata <= res;
        end
    end

endmodule

/* dv/tb_zstd_frame_header_parser_core.sv */
`timescale 1ns / 1ps

module tb_zstd_frame_header_parser_core;
    import zfhp_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 4;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int BYTES_PER_PHASE = 115;
    localparam int NUM_PHASES = 7;

    localparam int FILL_RAND = 0;
    localparam int FILL_ZERO = 1;
    localparam int FILL_ONES = 2;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_word    i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_word   o_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    zstd_frame_header_parser_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    t_in_word  tx_q[$];
    t_out_word hdr_exp_q[$];
    int        n_queued = 0;
    int        n_mismatch = 0;
    int        quiet_cycles = 0;
    int        tx_gap = 0;
    int        rx_stall = 0;
    int        rx_hold = 0;
    logic      rx_hold_go = 1'b0;
    logic      rx_hold_seen = 1'b0;
    logic      idle_en = 1'b1;

    // header parser shadow state
    logic [31:0] magic_cfg = MAGIC_RESET;
    t_phase      hp_phase = PH_IDLE;
    logic [4:0]  hp_pos = '0;
    logic [31:0] hp_magic = '0;
    logic [7:0]  hp_desc = '0;
    logic [7:0]  hp_win = '0;
    logic [31:0] hp_dict = '0;
    logic [63:0] hp_size = '0;
    logic [3:0]  hp_left = '0;

    function automatic int unsigned dict_bytes(input logic [7:0] d);
        case (d[1:0])
            2'd0:    return 0;
            2'd1:    return 1;
            2'd2:    return 2;
            default: return 4;
        endcase
    endfunction

    function automatic int unsigned size_bytes(input logic [7:0] d);
        case (d[7:6])
            2'd0:    return d[5] ? 1 : 0;
            2'd1:    return 2;
            2'd2:    return 4;
            default: return 8;
        endcase
    endfunction

    task automatic finish_header(input logic bad_magic);
        t_out_word   r;
        int unsigned sb;
        sb = size_bytes(hp_desc);
        r = '0;
        r.status = bad_magic;
        r.header_length = hp_pos;
        if (!bad_magic) begin
            r.size_flag = hp_desc[7:6];
            r.single_seg = hp_desc[5];
            r.checksum_flag = hp_desc[2];
            r.dict_flag = hp_desc[1:0];
            r.window_present = !hp_desc[5];
            r.window_desc = hp_desc[5] ? 8'h00 : hp_win;
            r.dict_id = (dict_bytes(hp_desc) != 0) ? hp_dict : 32'd0;
            r.size_present = (sb != 0);
            if (sb == 2) begin
                r.content_size = hp_size + 64'(TWO_BYTE_BIAS);
            end else if (sb != 0) begin
                r.content_size = hp_size;
            end
        end
        hp_phase = PH_DONE;
        hp_left = '0;
        hdr_exp_q.push_back(r);
    endtask

    task automatic next_field(input t_phase fld);
        int unsigned db;
        int unsigned sb;
        db = dict_bytes(hp_desc);
        sb = size_bytes(hp_desc);
        if (fld == PH_DESC && !hp_desc[5]) begin
            hp_phase = PH_WINDOW;
            hp_left = 4'd1;
        end else if (fld != PH_DICT && fld != PH_SIZE && db != 0) begin
            hp_phase = PH_DICT;
            hp_left = 4'(db);
        end else if (fld != PH_SIZE && sb != 0) begin
            hp_phase = PH_SIZE;
            hp_left = 4'(sb);
        end else begin
            finish_header(1'b0);
        end
    endtask

    task automatic parse_byte(input t_in_word w);
        int unsigned k;
        if (w.sof) begin
            hp_phase = PH_MAGIC;
            hp_pos = '0;
            hp_magic = '0;
            hp_desc = '0;
            hp_win = '0;
            hp_dict = '0;
            hp_size = '0;
            hp_left = '0;
        end
        if (hp_phase == PH_IDLE || hp_phase == PH_DONE) begin
            return;
        end
        hp_pos = hp_pos + 5'd1;
        case (hp_phase)
            PH_MAGIC: begin
                k = (int'(hp_pos) - 1) & 3;
                hp_magic[8*k +: 8] = w.data_byte;
                if (hp_pos == 5'd4) begin
                    if (hp_magic != magic_cfg) begin
                        finish_header(1'b1);
                    end else begin
                        hp_phase = PH_DESC;
                    end
                end
            end
            PH_DESC: begin
                hp_desc = w.data_byte;
                next_field(PH_DESC);
            end
            PH_WINDOW: begin
                hp_win = w.data_byte;
                next_field(PH_WINDOW);
            end
            PH_DICT: begin
                k = dict_bytes(hp_desc) - hp_left;
                hp_dict[8*k +: 8] = w.data_byte;
                hp_left = hp_left - 4'd1;
                if (hp_left == 0) begin
                    next_field(PH_DICT);
                end
            end
            PH_SIZE: begin
                k = size_bytes(hp_desc) - hp_left;
                hp_size[8*k +: 8] = w.data_byte;
                hp_left = hp_left - 4'd1;
                if (hp_left == 0) begin
                    next_field(PH_SIZE);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic put_byte(input logic [7:0] b, input logic fs);
        t_in_word w;
        w.data_byte = b;
        w.sof = fs;
        tx_q.push_back(w);
        n_queued++;
    endtask

    // a cut above 0 and below the header length truncates the header to that many words
    task automatic push_frame(input logic [31:0] magic, input logic [7:0] desc,
                              input int fill, input int cut, input int tail);
        logic [7:0] hdr [18];
        int         n;
        int         lim;
        for (int i = 0; i < 4; i++) begin
            hdr[i] = magic[8*i +: 8];
        end
        hdr[4] = desc;
        n = 5 + (desc[5] ? 0 : 1) + dict_bytes(desc) + size_bytes(desc);
        for (int i = 5; i < n; i++) begin
            hdr[i] = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF : 8'($urandom);
        end
        lim = (cut > 0 && cut < n) ? cut : n;
        for (int i = 0; i < lim; i++) begin
            put_byte(hdr[i], i == 0);
        end
        repeat (tail) put_byte(8'($urandom), 1'b0);
    endtask

    task automatic push_random_frame();
        int unsigned pick;
        logic [31:0] m;
        pick = $urandom_range(0, 99);
        m = magic_cfg;
        if (pick < 4) begin
            m = $urandom;
        end else if (pick < 8) begin
            m = magic_cfg ^ (32'd1 << $urandom_range(0, 31));
        end
        if (pick >= 8 && pick < 16) begin
            push_frame(m, 8'($urandom), FILL_RAND, $urandom_range(1, 17), 0);
        end else if (pick >= 16 && pick < 21) begin
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end else begin
            push_frame(m, 8'($urandom), FILL_RAND, 0, $urandom_range(0, 2));
        end
    endtask

    task automatic write_magic(input logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(CFG_IDX_MAGIC) << 2;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        magic_cfg = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (tx_q.size() != 0 || i_valid || hdr_exp_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (i_valid && o_ready) begin
                parse_byte(i_data);
            end
            if (!i_valid || o_ready) begin
                if (tx_gap != 0) begin
                    tx_gap <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (tx_q.size() != 0) begin
                    i_valid <= 1'b1;
                    i_data <= tx_q.pop_front();
                    if (idle_en && $urandom_range(0, 5) == 0) begin
                        tx_gap <= $urandom_range(1, 16);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // header result monitor
    always @(posedge i_clk) begin : rx_mon
        t_out_word want;
        string     bad;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_stall <= 0;
            rx_hold <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (hdr_exp_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("unexpected header word %h", o_data);
                    end
                end else begin
                    want = hdr_exp_q.pop_front();
                    bad = "";
                    if (o_data.status !== want.status) bad = {bad, " status"};
                    if (o_data.size_flag !== want.size_flag) bad = {bad, " size_flag"};
                    if (o_data.single_seg !== want.single_seg) bad = {bad, " single_seg"};
                    if (o_data.checksum_flag !== want.checksum_flag) bad = {bad, " checksum_flag"};
                    if (o_data.dict_flag !== want.dict_flag) bad = {bad, " dict_flag"};
                    if (o_data.window_present !== want.window_present) bad = {bad, " window_present"};
                    if (o_data.window_desc !== want.window_desc) bad = {bad, " window_desc"};
                    if (o_data.dict_id !== want.dict_id) bad = {bad, " dict_id"};
                    if (o_data.size_present !== want.size_present) bad = {bad, " size_present"};
                    if (o_data.content_size !== want.content_size) bad = {bad, " content_size"};
                    if (o_data.header_length !== want.header_length) bad = {bad, " header_length"};
                    if (bad != "") begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("header word mismatch:%s exp %h got %h", bad, want, o_data);
                        end
                    end
                end
            end
            if (rx_hold_go != rx_hold_seen) begin
                rx_hold_seen <= rx_hold_go;
                rx_hold <= RX_HOLD_CYCLES;
                i_ready <= 1'b0;
            end else if (rx_hold != 0) begin
                rx_hold <= rx_hold - 1;
                i_ready <= 1'b0;
            end else if (rx_stall != 0) begin
                rx_stall <= rx_stall - 1;
                i_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                rx_stall <= $urandom_range(0, 15);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [31:0] m;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        push_frame(32'h0000_0000, 8'h00, FILL_ZERO, 0, 1);  // bad magic
        push_frame(MAGIC_RESET, 8'h20, FILL_ONES, 0, 0);    // single segment, 1-byte size
        push_frame(MAGIC_RESET, 8'h00, FILL_ZERO, 0, 0);    // window only
        push_frame(MAGIC_RESET, 8'hE3, FILL_ONES, 0, 0);    // 8-byte size and 4-byte dictionary ID, no window
        push_frame(MAGIC_RESET, 8'hC0, FILL_RAND, 7, 0);    // restarted mid-header
        push_frame(MAGIC_RESET, 8'h45, FILL_ONES, 0, 1);    // 2-byte size, checksum
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       m = 32'h0000_0000;
                1:       m = 32'hFFFF_FFFF;
                5:       m = MAGIC_RESET;
                default: m = $urandom;
            endcase
            write_magic(m);
            idle_en <= !(ph == 3 || ph == NUM_PHASES - 1);
            n_queued = 0;
            while (n_queued < BYTES_PER_PHASE) begin
                push_random_frame();
            end
            if (ph == 2) begin
                rx_hold_go <= ~rx_hold_go;
            end
            wait_drained();
        end

        if (n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
